FILE: hdl/vmpc_pkg.sv
// Package for the VMPC stream cipher unit: sizes, datapath operation codes,
// and the command and status structs shared by the controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package vmpc_pkg;

    localparam int BYTE_W            = 8;
    localparam int SBOX_DEPTH        = 256;
    localparam int KEY_DEPTH_DEFAULT = 256;

    localparam int OP_W = 4;

    localparam logic [OP_W-1:0] OP_IDLE = 4'd0;
    localparam logic [OP_W-1:0] OP_FILL = 4'd1;
    localparam logic [OP_W-1:0] OP_M0   = 4'd2;
    localparam logic [OP_W-1:0] OP_M1   = 4'd3;
    localparam logic [OP_W-1:0] OP_M2   = 4'd4;
    localparam logic [OP_W-1:0] OP_M3   = 4'd5;
    localparam logic [OP_W-1:0] OP_D1   = 4'd6;
    localparam logic [OP_W-1:0] OP_D2   = 4'd7;
    localparam logic [OP_W-1:0] OP_D3   = 4'd8;
    localparam logic [OP_W-1:0] OP_D4   = 4'd9;
    localparam logic [OP_W-1:0] OP_D5   = 4'd10;
    localparam logic [OP_W-1:0] OP_D6   = 4'd11;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            key_accept;
        logic            data_accept;
        logic            sched_start;
        logic            finish;
    } vmpc_cmd_t;

    typedef struct packed {
        logic k_last;
    } vmpc_stat_t;

endpackage

FILE: hdl/vmpc_stream_cipher_unit.sv
// Top level of the VMPC stream cipher unit with an RC4-style key schedule.
// Depends on vmpc_pkg, vmpc_ctrl and vmpc_dp.
//
// The slave channel takes one word per item: tuser selects a key byte (0) or
// a data byte (1), tdata carries the byte, and tlast on a key byte marks the
// end of the key and starts the key schedule. The master channel returns one
// ciphertext word for each data byte and nothing for key bytes.
// A key byte is taken while the block stays idle. The last key byte is
// followed by the schedule: a pass rebuilds the identity permutation and
// another mixes in the key (four permutation RAM accesses per entry), with
// s_tready low. A data byte keeps s_tready low through states D1 to D6 after
// its acceptance, set by five dependent reads through the single read port
// of the permutation RAM and the two swap writes, so a new data byte is not
// taken before the last one is through. The result becomes valid in the same
// cycle that s_tready returns. After reset the block loads the identity
// permutation before s_tready rises. A result waits in the output register
// while the receiver stalls; the block keeps taking key bytes and works a
// following data byte up to its last step, holding until the output is free.
`timescale 1ns / 1ps

module vmpc_stream_cipher_unit
    import vmpc_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // data_byte[7:0]
    input  logic              s_tuser,   // func
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata    // out_byte[7:0]
);

    vmpc_cmd_t  cmd;
    vmpc_stat_t stat;

    vmpc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd),
        .stat    (stat)
    );

    vmpc_dp #(
        .KEY_DEPTH(KEY_DEPTH)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .m_tdata(m_tdata),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

FILE: hdl/vmpc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module vmpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/vmpc_ctrl.sv
// Controller state machine of the VMPC stream cipher unit: handshakes,
// clearing pass, key schedule and keystream sequencing. Depends on vmpc_pkg.
`timescale 1ns / 1ps

module vmpc_ctrl
    import vmpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tuser,
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output vmpc_cmd_t  cmd,
    input  vmpc_stat_t stat
);

    localparam logic [3:0] ST_FILL_RST = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_FILL_KEY = 4'd2;
    localparam logic [3:0] ST_M0       = 4'd3;
    localparam logic [3:0] ST_M1       = 4'd4;
    localparam logic [3:0] ST_M2       = 4'd5;
    localparam logic [3:0] ST_M3       = 4'd6;
    localparam logic [3:0] ST_D1       = 4'd7;
    localparam logic [3:0] ST_D2       = 4'd8;
    localparam logic [3:0] ST_D3       = 4'd9;
    localparam logic [3:0] ST_D4       = 4'd10;
    localparam logic [3:0] ST_D5       = 4'd11;
    localparam logic [3:0] ST_D6       = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       valid_reg;
    logic       valid_next;
    logic       accept;
    logic       slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;

    always_comb begin
        state_next      = state_reg;
        cmd.op          = OP_IDLE;
        cmd.key_accept  = 1'b0;
        cmd.data_accept = 1'b0;
        cmd.sched_start = 1'b0;
        cmd.finish      = 1'b0;
        case (state_reg)
            ST_FILL_RST: begin
                cmd.op = OP_FILL;
                if (stat.k_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.op = OP_IDLE;
                if (accept) begin
                    if (s_tuser) begin
                        cmd.data_accept = 1'b1;
                        state_next      = ST_D1;
                    end else begin
                        cmd.key_accept = 1'b1;
                        if (s_tlast) begin
                            cmd.sched_start = 1'b1;
                            state_next      = ST_FILL_KEY;
                        end
                    end
                end
            end
            ST_FILL_KEY: begin
                cmd.op = OP_FILL;
                if (stat.k_last) begin
                    state_next = ST_M0;
                end
            end
            ST_M0: begin
                cmd.op     = OP_M0;
                state_next = ST_M1;
            end
            ST_M1: begin
                cmd.op     = OP_M1;
                state_next = ST_M2;
            end
            ST_M2: begin
                cmd.op     = OP_M2;
                state_next = ST_M3;
            end
            ST_M3: begin
                cmd.op     = OP_M3;
                state_next = stat.k_last ? ST_IDLE : ST_M0;
            end
            ST_D1: begin
                cmd.op     = OP_D1;
                state_next = ST_D2;
            end
            ST_D2: begin
                cmd.op     = OP_D2;
                state_next = ST_D3;
            end
            ST_D3: begin
                cmd.op     = OP_D3;
                state_next = ST_D4;
            end
            ST_D4: begin
                cmd.op     = OP_D4;
                state_next = ST_D5;
            end
            ST_D5: begin
                cmd.op     = OP_D5;
                state_next = ST_D6;
            end
            ST_D6: begin
                cmd.op = OP_D6;
                if (slot_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.finish) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL_RST;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: hdl/vmpc_dp.sv
// Datapath of the VMPC stream cipher unit: permutation and key RAMs, index
// registers, keystream arithmetic and output register.
// Depends on vmpc_pkg and vmpc_ram.
`timescale 1ns / 1ps

module vmpc_dp
    import vmpc_pkg::*;
#(
    parameter int KEY_DEPTH = KEY_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [BYTE_W-1:0] s_tdata,
    output logic [BYTE_W-1:0] m_tdata,
    input  vmpc_cmd_t         cmd,
    output vmpc_stat_t        stat
);

    localparam int CW = $clog2(KEY_DEPTH + 1);
    localparam int KA = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int SA = $clog2(SBOX_DEPTH);

    logic [SA-1:0]     i_reg, i_next;
    logic [SA-1:0]     j_reg, j_next;
    logic [SA-1:0]     k_reg, k_next;
    logic [KA-1:0]     kk_reg, kk_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [BYTE_W-1:0] a_reg, a_next;
    logic [BYTE_W-1:0] b_reg, b_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [BYTE_W-1:0] ks_reg, ks_next;
    logic [BYTE_W-1:0] out_reg, out_next;

    logic              s_we;
    logic [SA-1:0]     s_waddr;
    logic [BYTE_W-1:0] s_wdata;
    logic [SA-1:0]     s_raddr;
    logic [BYTE_W-1:0] s_rdata;
    logic              key_we;
    logic [BYTE_W-1:0] key_rdata;
    logic [SA-1:0]     mix_sum;
    logic              kk_wrap;

    vmpc_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(SBOX_DEPTH)
    ) u_sbox (
        .aclk (aclk),
        .we   (s_we),
        .waddr(s_waddr),
        .wdata(s_wdata),
        .raddr(s_raddr),
        .rdata(s_rdata)
    );

    vmpc_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(KEY_DEPTH)
    ) u_key (
        .aclk (aclk),
        .we   (key_we),
        .waddr(count_reg[KA-1:0]),
        .wdata(s_tdata),
        .raddr(kk_reg),
        .rdata(key_rdata)
    );

    assign mix_sum     = j_reg + s_rdata + key_rdata;
    assign kk_wrap     = ((CW'(kk_reg) + CW'(1)) == count_reg);
    assign stat.k_last = (k_reg == {SA{1'b1}});
    assign m_tdata     = out_reg;

    always_comb begin
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        kk_next    = kk_reg;
        count_next = count_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        byte_next  = byte_reg;
        ks_next    = ks_reg;
        out_next   = out_reg;
        s_raddr    = i_reg;
        s_we       = 1'b0;
        s_waddr    = k_reg;
        s_wdata    = k_reg;
        key_we     = cmd.key_accept && (count_reg < CW'(KEY_DEPTH));
        if (key_we) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.data_accept) begin
            byte_next = s_tdata;
        end
        if (cmd.sched_start) begin
            j_next  = '0;
            kk_next = '0;
        end
        case (cmd.op)
            OP_FILL: begin
                s_we    = 1'b1;
                s_waddr = k_reg;
                s_wdata = k_reg;
                k_next  = k_reg + SA'(1);
            end
            OP_M0: begin
                s_raddr = k_reg;
            end
            OP_M1: begin
                s_raddr = mix_sum;
                j_next  = mix_sum;
                a_next  = s_rdata;
            end
            OP_M2: begin
                s_we    = 1'b1;
                s_waddr = k_reg;
                s_wdata = s_rdata;
            end
            OP_M3: begin
                s_we    = 1'b1;
                s_waddr = j_reg;
                s_wdata = a_reg;
                k_next  = k_reg + SA'(1);
                kk_next = kk_wrap ? '0 : kk_reg + KA'(1);
                if (stat.k_last) begin
                    i_next     = '0;
                    j_next     = '0;
                    count_next = '0;
                end
            end
            OP_D1: begin
                s_raddr = j_reg + s_rdata;
                a_next  = s_rdata;
            end
            OP_D2: begin
                s_raddr = s_rdata;
                j_next  = s_rdata;
            end
            OP_D3: begin
                s_raddr = s_rdata + SA'(1);
                b_next  = s_rdata;
            end
            OP_D4: begin
                s_raddr = s_rdata;
            end
            OP_D5: begin
                ks_next = s_rdata ^ byte_reg;
                s_we    = 1'b1;
                s_waddr = i_reg;
                s_wdata = b_reg;
            end
            OP_D6: begin
                s_we    = 1'b1;
                s_waddr = j_reg;
                s_wdata = a_reg;
                if (cmd.finish) begin
                    i_next   = i_reg + SA'(1);
                    out_next = ks_reg;
                end
            end
            default: begin
                s_raddr = i_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            kk_reg    <= '0;
            count_reg <= '0;
        end else begin
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            kk_reg    <= kk_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        byte_reg <= byte_next;
        ks_reg   <= ks_next;
        out_reg  <= out_next;
    end

endmodule

FILE: verif/vmpc_stream_cipher_unit_tb.sv
// Self-checking testbench for vmpc_stream_cipher_unit: streams key and data words,
// tracks the key schedule and keystream on its own, and compares every output word.
// Depends on vmpc_pkg and vmpc_stream_cipher_unit.
`timescale 1ns / 1ps

module vmpc_stream_cipher_unit_tb;
    import vmpc_pkg::*;

    localparam int KEY_SLOTS   = KEY_DEPTH_DEFAULT;
    localparam int ITEM_TARGET = 830;
    localparam int HOLD_CYCLES = 800;
    localparam int TAIL_CYCLES = 1400;

    localparam bit FUNC_KEY  = 1'b0;
    localparam bit FUNC_DATA = 1'b1;

    typedef logic [BYTE_W-1:0] octet_t;

    class cipher_tracker;
        octet_t      sbox [SBOX_DEPTH];
        octet_t      key_buf [SBOX_DEPTH];
        int unsigned key_len;
        octet_t      pos_i;
        octet_t      pos_j;
        octet_t      cipher_q [$];
        int unsigned errors;

        function new();
            init_sbox();
            key_len = 0;
            pos_i   = '0;
            pos_j   = '0;
            errors  = 0;
        endfunction

        function void init_sbox();
            for (int k = 0; k < SBOX_DEPTH; k++) begin
                sbox[k] = octet_t'(k);
            end
        endfunction

        function void swap_entries(octet_t a, octet_t b);
            octet_t t;
            t       = sbox[a];
            sbox[a] = sbox[b];
            sbox[b] = t;
        endfunction

        function void rekey();
            octet_t j;
            j = '0;
            init_sbox();
            for (int k = 0; k < SBOX_DEPTH; k++) begin
                j = j + sbox[k] + key_buf[k % key_len];
                swap_entries(octet_t'(k), j);
            end
            pos_i   = '0;
            pos_j   = '0;
            key_len = 0;
        endfunction

        function void note_word(bit func, octet_t val, bit last);
            octet_t j;
            octet_t t;
            if (func == FUNC_KEY) begin
                if (key_len < KEY_SLOTS) begin
                    key_buf[key_len] = val;
                    key_len++;
                end
                if (last) begin
                    rekey();
                end
            end else begin
                t = pos_j + sbox[pos_i];
                j = sbox[t];
                t = sbox[j] + 8'd1;
                t = sbox[t];
                cipher_q.push_back(sbox[t] ^ val);
                swap_entries(pos_i, j);
                pos_j = j;
                pos_i = pos_i + 8'd1;
            end
        endfunction

        function void check_cipher(octet_t got);
            octet_t want;
            if (cipher_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("Unexpected output word: actual %h", got);
                end
            end else begin
                want = cipher_q.pop_front();
                if (want !== got) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("Output word mismatch: expected %h, actual %h", want, got);
                    end
                end
            end
        endfunction

        function void close_out();
            if (cipher_q.size() != 0) begin
                errors += cipher_q.size();
                $display("Missing output words: %0d still expected", cipher_q.size());
            end
        endfunction
    endclass

    logic   aclk;
    logic   aresetn;
    logic   s_tvalid;
    logic   s_tready;
    octet_t s_tdata;
    logic   s_tuser;
    logic   s_tlast;
    logic   m_tvalid;
    logic   m_tready;
    octet_t m_tdata;

    cipher_tracker tracker = new();
    int            sent;
    bit            steady;
    bit            rx_hold_req;
    int            rx_hold_left;

    vmpc_stream_cipher_unit #(
        .KEY_DEPTH(KEY_SLOTS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_word(input bit func, input octet_t val, input bit last);
        while (!steady && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= val;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        tracker.note_word(func, val, last);
        sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (tracker.cipher_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        m_tready     = 1'b0;
        rx_hold_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 15);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_cipher(m_tdata);
        end
    end

    initial begin
        int key_words;
        int burst;
        int pick;
        int steady_from;
        bit steady_done;
        bit hold_done;
        bit overflow_done;

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = FUNC_KEY;
        s_tlast       = 1'b0;
        sent          = 0;
        steady        = 1'b0;
        rx_hold_req   = 1'b0;
        steady_from   = 0;
        steady_done   = 1'b0;
        hold_done     = 1'b0;
        overflow_done = 1'b0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Data ahead of any key runs on the reset permutation; tlast on data is ignored.
        send_word(FUNC_DATA, 8'h00, 1'b0);
        send_word(FUNC_DATA, 8'hFF, 1'b0);
        send_word(FUNC_DATA, 8'hA5, 1'b1);
        send_word(FUNC_KEY,  8'h00, 1'b1);
        send_word(FUNC_DATA, 8'hFF, 1'b0);
        send_word(FUNC_DATA, 8'h00, 1'b0);
        send_word(FUNC_KEY,  8'hFF, 1'b0);
        send_word(FUNC_KEY,  8'h01, 1'b0);
        send_word(FUNC_KEY,  8'h80, 1'b1);
        send_word(FUNC_DATA, 8'h5A, 1'b0);
        send_word(FUNC_DATA, 8'hFF, 1'b1);
        send_word(FUNC_DATA, 8'h00, 1'b0);
        send_word(FUNC_KEY,  8'hFF, 1'b1);
        send_word(FUNC_DATA, 8'h80, 1'b0);
        send_word(FUNC_DATA, 8'h7F, 1'b0);
        drain();

        while (sent < ITEM_TARGET) begin
            if (!steady_done && !steady && sent >= 200) begin
                steady      = 1'b1;
                steady_from = sent;
            end
            if (steady && sent >= steady_from + 180) begin
                steady      = 1'b0;
                steady_done = 1'b1;
            end
            if (!hold_done && sent >= 450) begin
                hold_done   = 1'b1;
                rx_hold_req = 1'b1;
                repeat (12) send_word(FUNC_DATA, octet_t'($urandom_range(255)), 1'b0);
                drain();
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_word(bit'($urandom_range(1)), octet_t'($urandom_range(255)),
                          bit'($urandom_range(1)));
            end else begin
                // Keys longer than the buffer must drop their surplus bytes.
                if (!overflow_done && sent >= 100) begin
                    key_words     = 260;
                    overflow_done = 1'b1;
                end else if (pick < 10) begin
                    key_words = $urandom_range(300, 200);
                end else begin
                    key_words = $urandom_range(12, 1);
                end
                for (int k = 0; k < key_words; k++) begin
                    send_word(FUNC_KEY, octet_t'($urandom_range(255)), k == key_words - 1);
                end
                burst = $urandom_range(40, 1);
                for (int k = 0; k < burst; k++) begin
                    send_word(FUNC_DATA, octet_t'($urandom_range(255)),
                              $urandom_range(9) == 0);
                end
                if ($urandom_range(9) == 0) begin
                    drain();
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        tracker.close_out();
        if (tracker.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
